[hw/rtl/sdws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdws_pkg
// Shared types and constants for the synthesizer divider word serializer.
// ----------------------------------------------------------------------------
package sdws_pkg;

    // Field widths
    localparam int WORD_BITS   = 32;
    localparam int TUNING_W    = 25;
    localparam int IF_W        = 17;
    localparam int N_W         = 18;
    localparam int REF_W       = 7;
    localparam int FREQ_W      = 18;   // LO frequency in kHz, max 164625
    localparam int KHZ_W       = 16;   // tuning_hz / 1000, max 33554
    localparam int Q1K_W       = 8;    // F / 1000, max 164
    localparam int Q100_W      = 11;   // F / 100, max 1646
    localparam int REM1K_W     = 10;
    localparam int REM100_W    = 7;
    localparam int N1_W        = 12;   // max 3499
    localparam int PAD_W       = WORD_BITS - REF_W - N_W - 1;
    localparam int CNT_W       = $clog2(WORD_BITS + 1);

    // Reset value of the IF offset register
    localparam logic [IF_W-1:0] IF_RESET_KHZ = 17'd65500;

    // Fixed reference dividers
    localparam logic [REF_W-1:0] REF_ONE   = 7'h64;
    localparam logic [REF_W-1:0] REF_TWO   = 7'h0A;
    localparam logic [REF_W-1:0] REF_THREE = 7'h64;

    // Reciprocal constants: floor(x / d) = (x * M) >> S, exact over the input range
    localparam int                 PROD_T_W     = 51;
    localparam logic [PROD_T_W-1:0] RECIP_T1K    = 51'd34359739;  // /1000, 25-bit x
    localparam int                 RECIP_T1K_SH = 35;
    localparam int                 PROD_F_W     = 37;
    localparam logic [PROD_F_W-1:0] RECIP_F1K    = 37'd268436;    // /1000, 18-bit x
    localparam int                 RECIP_F1K_SH = 28;
    localparam logic [PROD_F_W-1:0] RECIP_F100   = 37'd335545;    // /100, 18-bit x
    localparam int                 RECIP_F100_SH = 25;

    // Index of the latch beat in a run
    localparam logic [CNT_W-1:0] LATCH_BEAT = CNT_W'(WORD_BITS);

    // Three packed synthesizer words
    typedef struct packed {
        logic [WORD_BITS-1:0] one;
        logic [WORD_BITS-1:0] two;
        logic [WORD_BITS-1:0] three;
    } sdws_words_t;

    // Handshake between the arithmetic pipe and the serializer
    typedef struct packed {
        logic valid;
    } sdws_fwd_t;

    typedef struct packed {
        logic ready;
    } sdws_bwd_t;

endpackage

[hw/rtl/sdws_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdws_calc
// Six-stage pipe: tuning frequency in, three packed divider words out.
// ----------------------------------------------------------------------------
module sdws_calc (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sdws_pkg::TUNING_W-1:0]     s_tuning_hz,
    input  logic [sdws_pkg::IF_W-1:0]         if_offset,
    output sdws_pkg::sdws_fwd_t               out_fwd,
    input  sdws_pkg::sdws_bwd_t               out_bwd,
    output sdws_pkg::sdws_words_t             out_words
);
    import sdws_pkg::*;

    // Stage valid bits and per-stage enables
    logic [5:0] vld_reg;
    logic [5:0] en;
    logic [5:0] vin;

    // Stage payload registers
    logic [TUNING_W-1:0] tune_reg;
    logic [KHZ_W-1:0]    khz_reg;
    logic [FREQ_W-1:0]   f3_reg;
    logic [FREQ_W-1:0]   f4_reg;
    logic [Q1K_W-1:0]    q1k4_reg;
    logic [Q100_W-1:0]   q100_4_reg;
    logic [Q1K_W-1:0]    q1k5_reg;
    logic [Q100_W-1:0]   q100_5_reg;
    logic [REM1K_W-1:0]  rem1k_reg;
    logic [REM100_W-1:0] rem100_reg;
    sdws_words_t         words_reg;

    // Next values
    logic [PROD_T_W-1:0] prod_t;
    logic [KHZ_W-1:0]    khz_next;
    logic [FREQ_W-1:0]   f_next;
    logic [PROD_F_W-1:0] prod_f1k;
    logic [PROD_F_W-1:0] prod_f100;
    logic [Q1K_W-1:0]    q1k_next;
    logic [Q100_W-1:0]   q100_next;
    logic [REM1K_W-1:0]  rem1k_next;
    logic [REM100_W-1:0] rem100_next;
    logic                a_bit;
    logic [N1_W-1:0]     n1;
    logic [N_W-1:0]      n1_ext;
    logic [N_W-1:0]      n2;
    logic [Q100_W-1:0]   n3;
    logic [N_W-1:0]      n3_ext;
    sdws_words_t         words_next;

    // Ready chain: a stage moves when empty or when the next one moves
    always_comb begin
        en[5] = !vld_reg[5] || out_bwd.ready;
        for (int k = 4; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vin = {vld_reg[4:0], s_valid};
    end

    assign s_ready       = en[0];
    assign out_fwd.valid = vld_reg[5];
    assign out_words     = words_reg;

    // Stage 2: tuning / 1000 by reciprocal
    assign prod_t   = PROD_T_W'(tune_reg) * RECIP_T1K;
    assign khz_next = KHZ_W'(prod_t >> RECIP_T1K_SH);

    // Stage 3: add the IF offset
    assign f_next = FREQ_W'(khz_reg) + FREQ_W'(if_offset);

    // Stage 4: F / 1000 and F / 100
    assign prod_f1k  = PROD_F_W'(f3_reg) * RECIP_F1K;
    assign prod_f100 = PROD_F_W'(f3_reg) * RECIP_F100;
    assign q1k_next  = Q1K_W'(prod_f1k >> RECIP_F1K_SH);
    assign q100_next = Q100_W'(prod_f100 >> RECIP_F100_SH);

    // Stage 5: remainders
    assign rem1k_next  = REM1K_W'(f4_reg - FREQ_W'(q1k4_reg) * 18'd1000);
    assign rem100_next = REM100_W'(f4_reg - FREQ_W'(q100_4_reg) * 18'd100);

    // Stage 6: divider values and word packing
    always_comb begin
        a_bit  = (rem1k_reg >= 10'd500);
        n1     = N1_W'(rem1k_reg) + 12'd3000 - (a_bit ? 12'd1000 : 12'd0);
        n1_ext = N_W'(n1);
        n2     = N_W'(q1k5_reg) + N_W'(a_bit) - 18'd3;   // wraps below 2500 kHz
        n3     = q100_5_reg + Q100_W'(rem100_reg >= 7'd50);
        n3_ext = N_W'(n3);
        words_next.one   = {{PAD_W{1'b0}}, REF_ONE, n1_ext, 1'b0};
        // P=1 words: N bits 15..3 move up past a two-bit gap
        words_next.two   = {{PAD_W{1'b0}}, REF_TWO, n2[15:3], 2'b00, n2[2:0], 1'b1};
        words_next.three = {{PAD_W{1'b0}}, REF_THREE, n3_ext[15:3], 2'b00,
                            n3_ext[2:0], 1'b1};
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < 6; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vin[k];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en[0] && vin[0]) begin
            tune_reg <= s_tuning_hz;
        end
        if (en[1] && vin[1]) begin
            khz_reg <= khz_next;
        end
        if (en[2] && vin[2]) begin
            f3_reg <= f_next;
        end
        if (en[3] && vin[3]) begin
            f4_reg     <= f3_reg;
            q1k4_reg   <= q1k_next;
            q100_4_reg <= q100_next;
        end
        if (en[4] && vin[4]) begin
            q1k5_reg   <= q1k4_reg;
            q100_5_reg <= q100_4_reg;
            rem1k_reg  <= rem1k_next;
            rem100_reg <= rem100_next;
        end
        if (en[5] && vin[5]) begin
            words_reg <= words_next;
        end
    end

endmodule

[hw/rtl/synth_divider_word_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synth_divider_word_serializer
// Computes three synthesizer divider words from a tuning frequency and
// shifts them out MSB first, one bit per chip per transaction, then a latch.
// ----------------------------------------------------------------------------
// The first result follows the input through the six pipe stages and the shift-register load.
// Throughput: 33 result transactions per input (32 bits plus latch); the
//   one-beat-per-cycle shifter sets this while m_ready is high; runs follow each other with no gap.
// The arithmetic pipe holds up to six further inputs while the shifter runs.
// Reset: IF offset returns to 65500 kHz, pipe and shifter are emptied.
module synth_divider_word_serializer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration
    input  logic                           cfg_we,
    input  logic [sdws_pkg::IF_W-1:0]      cfg_wdata,
    // Input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sdws_pkg::TUNING_W-1:0]  s_tuning_hz,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_bit_chip_one,
    output logic                           m_bit_chip_two,
    output logic                           m_bit_chip_three,
    output logic                           m_latch_pulse,
    output logic                           m_last
);
    import sdws_pkg::*;

    logic [IF_W-1:0]      if_offset_reg;
    sdws_fwd_t            calc_fwd;
    sdws_bwd_t            calc_bwd;
    sdws_words_t          calc_words;

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [WORD_BITS-1:0] sh1_reg;
    logic [WORD_BITS-1:0] sh2_reg;
    logic [WORD_BITS-1:0] sh3_reg;
    logic                 beat_done;
    logic                 at_latch;
    logic                 load;

    // IF offset register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            if_offset_reg <= IF_RESET_KHZ;
        end else if (cfg_we) begin
            if_offset_reg <= cfg_wdata;
        end
    end

    // Arithmetic pipe
    sdws_calc u_calc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_tuning_hz (s_tuning_hz),
        .if_offset   (if_offset_reg),
        .out_fwd     (calc_fwd),
        .out_bwd     (calc_bwd),
        .out_words   (calc_words)
    );

    // Shifter control: take new words when idle or on the latch beat
    assign beat_done      = busy_reg && m_ready;
    assign at_latch       = (cnt_reg == LATCH_BEAT);
    assign calc_bwd.ready = !busy_reg || (beat_done && at_latch);
    assign load           = calc_bwd.ready && calc_fwd.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (beat_done) begin
            if (at_latch) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Shift registers; zeros fill in, so all bits are low on the latch beat
    always_ff @(posedge aclk) begin
        if (load) begin
            sh1_reg <= calc_words.one;
            sh2_reg <= calc_words.two;
            sh3_reg <= calc_words.three;
        end else if (beat_done) begin
            sh1_reg <= {sh1_reg[WORD_BITS-2:0], 1'b0};
            sh2_reg <= {sh2_reg[WORD_BITS-2:0], 1'b0};
            sh3_reg <= {sh3_reg[WORD_BITS-2:0], 1'b0};
        end
    end

    // Result outputs
    assign m_valid          = busy_reg;
    assign m_bit_chip_one   = sh1_reg[WORD_BITS-1];
    assign m_bit_chip_two   = sh2_reg[WORD_BITS-1];
    assign m_bit_chip_three = sh3_reg[WORD_BITS-1];
    assign m_latch_pulse    = at_latch;
    assign m_last           = at_latch;

endmodule
